// ----- hdl/t35enc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t35enc_pkg
// types, codes and constant bytes shared by the T.35 unit encapsulator
// ----------------------------------------------------------------------------
package t35enc_pkg;

  localparam int BYTE_W        = 8;
  localparam int PAYLOAD_LEN_W = 10;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int START_IDX_W   = 3;

  localparam logic [START_IDX_W-1:0] START_IDX_LAST = 3'd5;

  // register word index on the apb port
  localparam logic REG_CODEC_SELECT = 1'b0;

  localparam int SEI_NUT       = 39;
  localparam int OBU_META_KIND = 5;

  localparam logic [BYTE_W-1:0] NAL_HDR_0     = BYTE_W'(SEI_NUT << 1);
  localparam logic [BYTE_W-1:0] NAL_HDR_1     = 8'h01;
  localparam logic [BYTE_W-1:0] SEI_TYPE_T35  = 8'h04;
  localparam logic [BYTE_W-1:0] META_TYPE_T35 = 8'h04;
  localparam logic [BYTE_W-1:0] OBU_HDR       = BYTE_W'((OBU_META_KIND << 3) | 2);
  localparam logic [BYTE_W-1:0] TRAILER       = 8'h80;
  localparam logic [BYTE_W-1:0] EPB           = 8'h03;
  localparam logic [BYTE_W-1:0] FF_BYTE       = 8'hFF;
  localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;
  localparam logic [BYTE_W-1:0] ONE_BYTE      = 8'h01;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_TYPE,
    OP_SIZE,
    OP_OBU,
    OP_LEB,
    OP_META,
    OP_EPB,
    OP_DATA,
    OP_TRAIL
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [START_IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic inside_unit;
    logic codec;
    logic len_ge_ff;
    logic leb_more;
    logic need_epb;
    logic last;
  } status_t;

  // start code and nal header bytes of a prefix sei nal unit
  function automatic logic [BYTE_W-1:0] hevc_start_byte(input logic [START_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0, 3'd1, 3'd2: b = ZERO_BYTE;
      3'd3:             b = ONE_BYTE;
      3'd4:             b = NAL_HDR_0;
      3'd5:             b = NAL_HDR_1;
      default:          b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage : t35enc_pkg
`default_nettype wire

// ----- hdl/t35enc_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t35enc_in_if / t35enc_out_if
// valid/ready channels for payload bytes in and encapsulated bytes out
// ----------------------------------------------------------------------------
interface t35enc_in_if;
  import t35enc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [BYTE_W-1:0]        data_byte;
  logic                     unit_last;
  logic [PAYLOAD_LEN_W-1:0] payload_length;

  modport source (output valid, data_byte, unit_last, payload_length, input ready);
  modport sink   (input valid, data_byte, unit_last, payload_length, output ready);
endinterface : t35enc_in_if

interface t35enc_out_if;
  import t35enc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              unit_end;

  modport source (output valid, out_byte, run_last, unit_end, input ready);
  modport sink   (input valid, out_byte, run_last, unit_end, output ready);
endinterface : t35enc_out_if
`default_nettype wire

// ----- hdl/t35enc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t35enc_ctrl
// sequencer that walks header, escape, payload and trailer bytes of a unit
// ----------------------------------------------------------------------------
module t35enc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire t35enc_pkg::status_t status,
  output t35enc_pkg::cmd_t         cmd
);
  import t35enc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_TYPE,
    S_SIZE,
    S_OBU,
    S_LEB,
    S_META,
    S_DATA,
    S_TRAIL
  } state_t;

  state_t                 state;
  logic [START_IDX_W-1:0] idx;
  logic                   go;

  assign go       = status.out_free;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.idx = idx;
    unique case (state)
      S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
      S_START: if (go) cmd.op = OP_START;
      S_TYPE:  if (go) cmd.op = OP_TYPE;
      S_SIZE:  if (go) cmd.op = OP_SIZE;
      S_OBU:   if (go) cmd.op = OP_OBU;
      S_LEB:   if (go) cmd.op = OP_LEB;
      S_META:  if (go) cmd.op = OP_META;
      S_DATA:  if (go) cmd.op = status.need_epb ? OP_EPB : OP_DATA;
      S_TRAIL: if (go) cmd.op = OP_TRAIL;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx <= '0;
            priority if (status.inside_unit) state <= S_DATA;
            else if (status.codec)           state <= S_OBU;
            else                             state <= S_START;
          end
        end
        S_START: begin
          if (go) begin
            if (idx == START_IDX_LAST) state <= S_TYPE;
            else idx <= idx + START_IDX_W'(1);
          end
        end
        S_TYPE: if (go) state <= S_SIZE;
        S_SIZE: if (go && !status.len_ge_ff) state <= S_DATA;
        S_OBU:  if (go) state <= S_LEB;
        S_LEB:  if (go && !status.leb_more) state <= S_META;
        S_META: if (go) state <= S_DATA;
        S_DATA: begin
          if (go && !status.need_epb) state <= status.last ? S_TRAIL : S_IDLE;
        end
        S_TRAIL: if (go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : t35enc_ctrl
`default_nettype wire

// ----- hdl/t35enc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t35enc_dp
// item registers, size counters, zero-run tracking and the output word register
// ----------------------------------------------------------------------------
module t35enc_dp #(
  parameter int MAX_PAYLOAD = 1023
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire t35enc_pkg::cmd_t                     cmd,
  output t35enc_pkg::status_t                       status,
  input  wire logic                                 codec_select,
  input  wire logic [t35enc_pkg::BYTE_W-1:0]        data_byte,
  input  wire logic                                 unit_last,
  input  wire logic [t35enc_pkg::PAYLOAD_LEN_W-1:0] payload_length,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [t35enc_pkg::BYTE_W-1:0]             out_byte,
  output logic                                      run_last,
  output logic                                      unit_end
);
  import t35enc_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int SAT_W = (LEN_W > PAYLOAD_LEN_W) ? LEN_W : PAYLOAD_LEN_W;
  localparam int CMP_W = LEN_W + BYTE_W;
  localparam int LEB_W = $clog2(MAX_PAYLOAD + 3);

  logic [BYTE_W-1:0] data_q;
  logic              last_q;
  logic [LEN_W-1:0]  len;
  logic [LEB_W-1:0]  leb;
  logic [1:0]        zero_count;
  logic              inside_unit;

  logic [SAT_W-1:0]  len_ext;
  logic [LEN_W-1:0]  len_sat;
  logic              len_ge_ff;
  logic              leb_more;
  logic              need_epb;
  logic              emit;
  logic [BYTE_W-1:0] leb_byte;
  logic [BYTE_W-1:0] out_byte_next;
  logic              run_last_next;
  logic              unit_end_next;

  assign len_ext   = SAT_W'(payload_length);
  assign len_sat   = (len_ext > SAT_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(len_ext);
  assign len_ge_ff = CMP_W'(len) >= CMP_W'(FF_BYTE);
  assign leb_more  = (leb >> 7) != '0;
  assign leb_byte  = {leb_more, 7'(leb)};
  assign need_epb  = !codec_select && (zero_count == 2'd2) && (data_q[BYTE_W-1:2] == '0);
  assign emit      = (cmd.op != OP_NONE) && (cmd.op != OP_LOAD);

  always_comb begin
    status.out_free    = !out_valid || out_ready;
    status.inside_unit = inside_unit;
    status.codec       = codec_select;
    status.len_ge_ff   = len_ge_ff;
    status.leb_more    = leb_more;
    status.need_epb    = need_epb;
    status.last        = last_q;
  end

  // next output word
  always_comb begin
    run_last_next = 1'b0;
    unit_end_next = 1'b0;
    unique case (cmd.op)
      OP_START: out_byte_next = hevc_start_byte(cmd.idx);
      OP_TYPE:  out_byte_next = SEI_TYPE_T35;
      OP_SIZE:  out_byte_next = len_ge_ff ? FF_BYTE : BYTE_W'(len);
      OP_OBU:   out_byte_next = OBU_HDR;
      OP_LEB:   out_byte_next = leb_byte;
      OP_META:  out_byte_next = META_TYPE_T35;
      OP_EPB:   out_byte_next = EPB;
      OP_DATA: begin
        out_byte_next = data_q;
        run_last_next = !last_q;
      end
      OP_TRAIL: begin
        out_byte_next = TRAILER;
        run_last_next = 1'b1;
        unit_end_next = 1'b1;
      end
      default: out_byte_next = out_byte;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      zero_count  <= '0;
      inside_unit <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_START, OP_TYPE, OP_OBU, OP_META, OP_EPB, OP_TRAIL: zero_count <= '0;
        OP_SIZE: zero_count <= (!len_ge_ff && len == '0) ? 2'd1 : 2'd0;
        OP_DATA: begin
          if (codec_select || data_q != ZERO_BYTE) zero_count <= '0;
          else zero_count <= zero_count + 2'd1;
        end
        default: zero_count <= zero_count;
      endcase
      if (cmd.op == OP_DATA) inside_unit <= !last_q;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        data_q <= data_byte;
        last_q <= unit_last;
        len    <= len_sat;
        leb    <= LEB_W'(len_sat) + LEB_W'(2);
      end
      OP_SIZE: if (len_ge_ff) len <= LEN_W'(CMP_W'(len) - CMP_W'(FF_BYTE));
      OP_LEB:  leb <= leb >> 7;
      default: begin
      end
    endcase

    if (emit) begin
      out_byte <= out_byte_next;
      run_last <= run_last_next;
      unit_end <= unit_end_next;
    end
  end

endmodule : t35enc_dp
`default_nettype wire

// ----- hdl/t35_metadata_unit_encapsulator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t35_metadata_unit_encapsulator_top
// wraps T.35 payload bytes as an HEVC prefix SEI NAL unit or an AV1 metadata OBU
// ----------------------------------------------------------------------------
// One payload word is taken at a time: the word is loaded, then its byte is sent,
// with an emulation-prevention byte before it where needed and the trailer after
// the last word of a unit, and the first word of a unit is preceded by its
// header (HEVC: 7 words plus one per 255 of length plus one; AV1: 2 words plus
// the leb128 size bytes). The sequencer emits one word per cycle into a single
// output register while the output side keeps ready high. codec_select lives at
// byte address 0 of the APB port and is read afresh for every payload word.
module t35_metadata_unit_encapsulator_top #(
  parameter int MAX_PAYLOAD = 1023
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  t35enc_in_if.sink                                   t35,
  t35enc_out_if.source                                unit,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [t35enc_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [t35enc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [t35enc_pkg::APB_DATA_W-1:0]           prdata,
  output logic                                        pready
);
  import t35enc_pkg::*;

  logic    codec_select;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CODEC_SELECT) ? APB_DATA_W'(codec_select) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_select <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CODEC_SELECT) begin
      codec_select <= pwdata[0];
    end
  end

  t35enc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t35.valid),
    .in_ready (t35.ready),
    .status   (status),
    .cmd      (cmd)
  );

  t35enc_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .codec_select   (codec_select),
    .data_byte      (t35.data_byte),
    .unit_last      (t35.unit_last),
    .payload_length (t35.payload_length),
    .out_valid      (unit.valid),
    .out_ready      (unit.ready),
    .out_byte       (unit.out_byte),
    .run_last       (unit.run_last),
    .unit_end       (unit.unit_end)
  );

endmodule : t35_metadata_unit_encapsulator_top
`default_nettype wire

// ----- hdl/t35enc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// t35enc_checker
// port-level checks on the encapsulator, bound to the top level
// ----------------------------------------------------------------------------
module t35enc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [t35enc_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                            run_last,
  input wire logic                            unit_end
);
  import t35enc_pkg::*;

  // one payload word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_trailer_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_end |-> out_byte == TRAILER)
    else $error("unit end word is not the trailer");

  a_trailer_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_end |-> run_last)
    else $error("unit end word does not close its run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(unit_end))
    else $error("stalled output word changed");

endmodule : t35enc_checker

bind t35_metadata_unit_encapsulator_top t35enc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (t35.valid),
  .in_ready  (t35.ready),
  .out_valid (unit.valid),
  .out_ready (unit.ready),
  .out_byte  (unit.out_byte),
  .run_last  (unit.run_last),
  .unit_end  (unit.unit_end)
);
`default_nettype wire

// ----- test/t35_metadata_unit_encapsulator_top_test.sv -----
// ----------------------------------------------------------------------------
// t35_metadata_unit_encapsulator_top_test
// drives T.35 payload units through the encapsulator in both codec modes and
// compares every output word with a local model of the HEVC SEI and AV1 OBU
// framing, including escaping, length forms and mid-unit codec changes
// ----------------------------------------------------------------------------
module t35_metadata_unit_encapsulator_top_test;
  import t35enc_pkg::*;

  localparam logic CODEC_HEVC = 1'b0;
  localparam logic CODEC_AV1  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              unit_end;
  } enc_word_t;

  typedef logic [BYTE_W-1:0] payload_q_t[$];

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  t35enc_in_if  t35_ch ();
  t35enc_out_if unit_ch ();

  t35_metadata_unit_encapsulator_top u_top (
    .clk     (clk),
    .rst     (rst),
    .t35     (t35_ch),
    .unit    (unit_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state
  logic       codec_q;
  logic [1:0] zcount;
  logic       in_unit;
  enc_word_t  expected_words[$];

  bit in_idle;
  bit out_idle;
  int n_fail;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void push_word(input logic [BYTE_W-1:0] b, input logic end_flag);
    enc_word_t w;
    w.out_byte = b;
    w.run_last = 1'b0;
    w.unit_end = end_flag;
    expected_words = {expected_words, w};
  endfunction

  // rbsp byte, escaped in hevc mode
  function automatic void push_rbsp(input logic [BYTE_W-1:0] b);
    if (codec_q == CODEC_HEVC) begin
      if (zcount == 2'd2 && b <= EPB) begin
        push_word(EPB, 1'b0);
        zcount = 2'd0;
      end
      push_word(b, 1'b0);
      zcount = (b == ZERO_BYTE) ? zcount + 2'd1 : 2'd0;
    end else begin
      push_word(b, 1'b0);
      zcount = 2'd0;
    end
  endfunction

  function automatic void encapsulate_word(input logic [BYTE_W-1:0] d, input logic last,
                                           input logic [PAYLOAD_LEN_W-1:0] len);
    int          rem;
    int          leb;
    logic [7:0]  lb;
    if (!in_unit) begin
      if (codec_q == CODEC_HEVC) begin
        push_word(ZERO_BYTE, 1'b0);
        push_word(ZERO_BYTE, 1'b0);
        push_word(ZERO_BYTE, 1'b0);
        push_word(ONE_BYTE, 1'b0);
        push_word(NAL_HDR_0, 1'b0);
        push_word(NAL_HDR_1, 1'b0);
        zcount = 2'd0;
        push_rbsp(SEI_TYPE_T35);
        rem = int'(len);
        while (rem >= int'(FF_BYTE)) begin
          push_rbsp(FF_BYTE);
          rem -= int'(FF_BYTE);
        end
        push_rbsp(8'(rem));
      end else begin
        push_word(OBU_HDR, 1'b0);
        leb = int'(len) + 2;
        do begin
          lb = 8'(leb & 'h7F);
          leb = leb >> 7;
          if (leb != 0) lb[7] = 1'b1;
          push_word(lb, 1'b0);
        end while (leb != 0);
        push_word(META_TYPE_T35, 1'b0);
        zcount = 2'd0;
      end
      in_unit = 1'b1;
    end
    push_rbsp(d);
    if (last) begin
      push_word(TRAILER, 1'b1);
      zcount  = 2'd0;
      in_unit = 1'b0;
    end
    expected_words[expected_words.size()-1].run_last = 1'b1;
  endfunction

  // output side: random stalls per word while out_idle is set
  initial begin
    int stall;
    unit_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 16) : 0;
      repeat (stall) begin
        unit_ch.ready = 1'b0;
        @(negedge clk);
      end
      unit_ch.ready = 1'b1;
      do @(posedge clk); while (rst || unit_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    enc_word_t exp_w;
    if (!rst && unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", unit_ch.out_byte);
        n_fail++;
      end else begin
        exp_w = expected_words.pop_front();
        if (unit_ch.out_byte !== exp_w.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_w.out_byte, unit_ch.out_byte);
          n_fail++;
        end
        if (unit_ch.run_last !== exp_w.run_last) begin
          $error("run_last: expected %b, got %b", exp_w.run_last, unit_ch.run_last);
          n_fail++;
        end
        if (unit_ch.unit_end !== exp_w.unit_end) begin
          $error("unit_end: expected %b, got %b", exp_w.unit_end, unit_ch.unit_end);
          n_fail++;
        end
      end
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] d, input logic last,
                           input logic [PAYLOAD_LEN_W-1:0] len);
    int gap;
    gap = in_idle ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    repeat (gap) begin
      t35_ch.valid = 1'b0;
      @(negedge clk);
    end
    t35_ch.valid          = 1'b1;
    t35_ch.data_byte      = d;
    t35_ch.unit_last      = last;
    t35_ch.payload_length = len;
    do @(posedge clk); while (t35_ch.ready !== 1'b1);
    encapsulate_word(d, last, len);
  endtask

  // length field only counts on the first word, the rest carry noise
  task automatic send_unit(input payload_q_t body, input logic [PAYLOAD_LEN_W-1:0] len);
    for (int i = 0; i < body.size(); i++) begin
      send_word(body[i], i == body.size() - 1, (i == 0) ? len : PAYLOAD_LEN_W'($urandom));
    end
  endtask

  task automatic drain_block();
    @(negedge clk);
    t35_ch.valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_codec(input logic c);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_ADDR_W'(4 * REG_CODEC_SELECT);
    pwdata  = APB_DATA_W'(c);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    codec_q = c;
    @(negedge clk);
    if (prdata !== APB_DATA_W'(c)) begin
      $error("prdata: expected %h, got %h", APB_DATA_W'(c), prdata);
      n_fail++;
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic test_hevc_headers();
    write_codec(CODEC_HEVC);
    in_idle  = 1'b0;
    out_idle = 1'b0;
    send_unit('{8'h00}, 10'd1);
    in_idle  = 1'b1;
    out_idle = 1'b1;
    // zero length, zero run starts in the size byte
    send_unit('{8'h00, 8'h00, 8'h01}, 10'd0);
    send_unit('{8'h00, 8'h00, 8'h02, 8'hFF}, 10'd1023);
    in_idle = 1'b0;
    send_unit('{8'h00, 8'h00, 8'h00, 8'h03}, 10'd255);
    drain_block();
  endtask

  task automatic test_av1_headers();
    write_codec(CODEC_AV1);
    out_idle = 1'b0;
    send_unit('{8'h00, 8'h00, 8'h00}, 10'd0);
    send_unit('{8'hFF}, 10'd126);
    in_idle = 1'b1;
    send_unit('{8'hA5}, 10'd125);
    send_unit('{8'h01}, 10'd1023);
    drain_block();
  endtask

  task automatic test_codec_switch();
    write_codec(CODEC_HEVC);
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_word(8'h00, 1'b0, 10'd2);
    send_word(8'h00, 1'b0, 10'd0);
    drain_block();
    write_codec(CODEC_AV1);
    send_word(8'h00, 1'b0, 10'd0);
    send_word(8'h03, 1'b0, 10'd0);
    drain_block();
    write_codec(CODEC_HEVC);
    send_word(8'h00, 1'b0, 10'd0);
    send_word(8'h00, 1'b0, 10'd0);
    send_word(8'h01, 1'b1, 10'd0);
    drain_block();
  endtask

  task automatic test_random_units(input int n_words);
    int         sent;
    int         phase;
    int         k;
    int         ulen;
    payload_q_t body;
    logic [PAYLOAD_LEN_W-1:0] len;
    sent  = 0;
    phase = 0;
    while (sent < n_words) begin
      drain_block();
      write_codec((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
      in_idle  = 1'($urandom_range(0, 1));
      out_idle = 1'($urandom_range(0, 1));
      k = 0;
      while (k < 25 && sent < n_words) begin
        ulen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        body.delete();
        repeat (ulen) begin
          case ($urandom_range(0, 3))
            0:       body = {body, ZERO_BYTE};
            1:       body = {body, 8'($urandom_range(1, 3))};
            default: body = {body, 8'($urandom_range(0, 255))};
          endcase
        end
        len = ($urandom_range(0, 4) == 0) ? PAYLOAD_LEN_W'($urandom_range(0, 1023))
                                          : PAYLOAD_LEN_W'(ulen);
        send_unit(body, len);
        k    += ulen;
        sent += ulen;
      end
      phase++;
    end
  endtask

  initial begin
    rst                   = 1'b1;
    t35_ch.valid          = 1'b0;
    t35_ch.data_byte      = '0;
    t35_ch.unit_last      = 1'b0;
    t35_ch.payload_length = '0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    codec_q               = CODEC_HEVC;
    zcount                = 2'd0;
    in_unit               = 1'b0;
    n_fail                = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_hevc_headers();
    test_av1_headers();
    test_codec_switch();
    test_random_units(175);

    drain_block();
    repeat (20) @(posedge clk);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
